// File: rtl/core/floor_ceiling_texel_caster_assert.svh
// Assertion macros for the floor/ceiling texel caster.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef FLOOR_CEILING_TEXEL_CASTER_ASSERT_SVH
`define FLOOR_CEILING_TEXEL_CASTER_ASSERT_SVH

// Consequence must hold in the same cycle as the condition
`define FCC_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("fcc assertion failed");

// Consequence must hold in the cycle after the condition
`define FCC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("fcc assertion failed");

`endif

// File: rtl/core/fcc_pkg.sv
// Shared types, constants and helpers for the floor/ceiling texel caster.
// Used by the divider cell, the axis unit and the top level.
package fcc_pkg;

  localparam int DIV_BITS     = 24;
  localparam int MAX_ROWS     = 1024;
  localparam int MAX_TEXTURE  = 1024;

  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  // Tile fraction bits: tile log2 plus 8 fraction bits
  localparam logic [4:0] FBITS_MIN  = 5'd15;
  localparam logic [4:0] FBITS_MAX  = 5'd16;
  localparam logic [4:0] FBITS_CEIL = 5'd17;

  // Register indexes
  localparam logic [2:0] REG_CENTER_ROW  = 3'd0;
  localparam logic [2:0] REG_SCREEN_H    = 3'd1;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_EYE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_PROJ_DIST   = 3'd4;
  localparam logic [2:0] REG_TEX_WIDTH   = 3'd5;
  localparam logic [2:0] REG_TEX_HEIGHT  = 3'd6;
  localparam logic [2:0] REG_TILE_LOG2   = 3'd7;

  // Divider state handed from cell to cell
  typedef struct packed {
    logic        sat;
    logic [24:0] rem;
    logic [24:0] den;
    logic [23:0] num_lo;
    logic [23:0] quo;
  } div_t;

  // Per-pixel data riding alongside the divider
  typedef struct packed {
    logic               region;
    logic [4:0]         fbits;
    logic [23:0]        px;
    logic [23:0]        py;
    logic signed [15:0] ca;
    logic signed [15:0] sa;
    logic [20:0]        dest;
  } side_t;

  // Zero acts as one, oversize acts as the largest texture
  function automatic logic [10:0] clamp_tex(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'(MAX_TEXTURE)) r = 11'(MAX_TEXTURE);
    return r;
  endfunction

endpackage

// File: rtl/core/floor_ceiling_texel_caster.sv
// Floor/ceiling texel caster: one screen pixel in, one texel address out per clock
// when the output side is not stalled. The pipeline is 32 stages deep: three setup
// stages, a chain of 24 divider cells that each produce one bit of the Q16.8
// distance, four axis stages and an output register. It takes one request per cycle
// while the output side is not stalled. A stall fills bubbles first, so requests keep
// flowing until every stage holds one. Configuration is read live and is to be
// changed only while the pipeline is empty.
// Depends on fcc_pkg, fcc_div_cell, fcc_axis and the assertion macro header.
`include "floor_ceiling_texel_caster_assert.svh"

module floor_ceiling_texel_caster (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row[9:0], column[20:10], player_x[44:21], player_y[68:45],
  // dir_x[84:69], dir_y[100:85], view_cos[115:101], zero fill
  input  logic [119:0] in_tdata,
  // surface[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // texel_x[9:0], texel_y[19:10], source_index[39:20], dst_index[60:40], zero fill
  output logic [63:0]  out_tdata,
  // in_region[0]
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int NS    = 32;
  localparam int CELL0 = 3;
  localparam int AX0   = CELL0 + fcc_pkg::DIV_BITS;

  // Configuration registers
  logic [9:0]  center_row_r;
  logic [10:0] screen_height_r;
  logic [11:0] dest_width_r;
  logic [15:0] eye_height_r;
  logic [11:0] proj_distance_r;
  logic [10:0] texture_width_r;
  logic [10:0] texture_height_r;
  logic [3:0]  floor_tile_log2_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r      <= 10'd240;
      screen_height_r   <= 11'd480;
      dest_width_r      <= 12'd640;
      eye_height_r      <= 16'd512;
      proj_distance_r   <= 12'd554;
      texture_width_r   <= 11'd64;
      texture_height_r  <= 11'd64;
      floor_tile_log2_r <= 4'd8;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        fcc_pkg::REG_CENTER_ROW: center_row_r      <= cfg_pwdata[9:0];
        fcc_pkg::REG_SCREEN_H:   screen_height_r   <= cfg_pwdata[10:0];
        fcc_pkg::REG_DEST_WIDTH: dest_width_r      <= cfg_pwdata[11:0];
        fcc_pkg::REG_EYE_HEIGHT: eye_height_r      <= cfg_pwdata[15:0];
        fcc_pkg::REG_PROJ_DIST:  proj_distance_r   <= cfg_pwdata[11:0];
        fcc_pkg::REG_TEX_WIDTH:  texture_width_r   <= cfg_pwdata[10:0];
        fcc_pkg::REG_TEX_HEIGHT: texture_height_r  <= cfg_pwdata[10:0];
        default:                 floor_tile_log2_r <= cfg_pwdata[3:0];
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (cfg_paddr[4:2])
      fcc_pkg::REG_CENTER_ROW: cfg_prdata = {22'd0, center_row_r};
      fcc_pkg::REG_SCREEN_H:   cfg_prdata = {21'd0, screen_height_r};
      fcc_pkg::REG_DEST_WIDTH: cfg_prdata = {20'd0, dest_width_r};
      fcc_pkg::REG_EYE_HEIGHT: cfg_prdata = {16'd0, eye_height_r};
      fcc_pkg::REG_PROJ_DIST:  cfg_prdata = {20'd0, proj_distance_r};
      fcc_pkg::REG_TEX_WIDTH:  cfg_prdata = {21'd0, texture_width_r};
      fcc_pkg::REG_TEX_HEIGHT: cfg_prdata = {21'd0, texture_height_r};
      default:                 cfg_prdata = {28'd0, floor_tile_log2_r};
    endcase
  end

  // Effective sizes after clamping
  logic [10:0] tw_eff, th_eff, sh_eff;
  logic [4:0]  fbits_floor;

  assign tw_eff = fcc_pkg::clamp_tex(texture_width_r);
  assign th_eff = fcc_pkg::clamp_tex(texture_height_r);
  assign sh_eff = (screen_height_r > 11'(fcc_pkg::MAX_ROWS)) ?
                  11'(fcc_pkg::MAX_ROWS) : screen_height_r;

  always_comb begin
    if (floor_tile_log2_r < 4'd8) fbits_floor = fcc_pkg::FBITS_MIN;
    else fbits_floor = fcc_pkg::FBITS_MAX;
  end

  // Stage valid bits and the ready chain running back from the output
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Input unpack
  logic               in_surface;
  logic [9:0]         in_row;
  logic [10:0]        in_column;
  logic [14:0]        in_cb;

  assign in_surface = in_tuser;
  assign in_row     = in_tdata[9:0];
  assign in_column  = in_tdata[20:10];
  assign in_cb      = in_tdata[115:101];

  // Stage 1: region test and row distance from the horizon
  fcc_pkg::side_t s1_side_r;
  logic [9:0]     s1_d_r, s1_row_r;
  logic [10:0]    s1_col_r;
  logic [14:0]    s1_cb_r;
  fcc_pkg::side_t s1_nxt;
  logic [9:0]     d_nxt;

  always_comb begin
    s1_nxt.px   = in_tdata[44:21];
    s1_nxt.py   = in_tdata[68:45];
    s1_nxt.ca   = in_tdata[84:69];
    s1_nxt.sa   = in_tdata[100:85];
    s1_nxt.dest = '0;
    if (!in_surface) begin
      s1_nxt.region = (in_row > center_row_r) && ({1'b0, in_row} < sh_eff);
      d_nxt         = in_row - center_row_r;
      s1_nxt.fbits  = fbits_floor;
    end else begin
      s1_nxt.region = in_row < center_row_r;
      d_nxt         = center_row_r - in_row;
      s1_nxt.fbits  = fcc_pkg::FBITS_CEIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_side_r <= s1_nxt;
      s1_d_r    <= d_nxt;
      s1_row_r  <= in_row;
      s1_col_r  <= in_column;
      s1_cb_r   <= in_cb;
    end
  end

  // Stage 2: numerator, denominator and destination index
  fcc_pkg::side_t s2_side_r;
  fcc_pkg::side_t s2_nxt;
  logic [27:0]    s2_num_r;
  logic [24:0]    s2_den_r;

  always_comb begin
    s2_nxt      = s1_side_r;
    s2_nxt.dest = 21'({12'd0, s1_row_r} * {10'd0, dest_width_r} + {11'd0, s1_col_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_side_r <= s2_nxt;
      s2_num_r  <= {12'd0, eye_height_r} * {16'd0, proj_distance_r};
      s2_den_r  <= {10'd0, s1_cb_r} * {15'd0, s1_d_r};
    end
  end

  // Stage 3: saturation test and divider setup
  fcc_pkg::div_t  s3_div_r;
  fcc_pkg::side_t s3_side_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_div_r.sat    <= {3'd0, s2_num_r[27:6]} >= s2_den_r;
      s3_div_r.rem    <= {3'd0, s2_num_r[27:6]};
      s3_div_r.den    <= s2_den_r;
      s3_div_r.num_lo <= {s2_num_r[5:0], 18'd0};
      s3_div_r.quo    <= '0;
      s3_side_r       <= s2_side_r;
    end
  end

  // Divider chain, one quotient bit per cell
  fcc_pkg::div_t  div_c  [fcc_pkg::DIV_BITS+1];
  fcc_pkg::side_t side_c [fcc_pkg::DIV_BITS+1];

  assign div_c[0]  = s3_div_r;
  assign side_c[0] = s3_side_r;

  for (genvar k = 0; k < fcc_pkg::DIV_BITS; k++) begin : g_cell
    fcc_div_cell u_cell (
      .clk    (clk),
      .en     (rdy[CELL0+k]),
      .div_i  (div_c[k]),
      .side_i (side_c[k]),
      .div_o  (div_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  fcc_pkg::side_t dv_side;
  logic [23:0]    span;

  assign dv_side = side_c[fcc_pkg::DIV_BITS];
  assign span = div_c[fcc_pkg::DIV_BITS].sat ? fcc_pkg::DIST_MAX :
                div_c[fcc_pkg::DIV_BITS].quo;

  // Axis units
  logic [3:0] ax_en;
  logic [9:0] tx, ty;

  assign ax_en = rdy[AX0+3:AX0];

  fcc_axis u_axis_x (
    .clk   (clk),
    .en    (ax_en),
    .span  (span),
    .pos   (dv_side.px),
    .trig  (dv_side.ca),
    .fbits (dv_side.fbits),
    .tex   (tw_eff),
    .texel (tx)
  );

  fcc_axis u_axis_y (
    .clk   (clk),
    .en    (ax_en),
    .span  (span),
    .pos   (dv_side.py),
    .trig  (dv_side.sa),
    .fbits (dv_side.fbits),
    .tex   (th_eff),
    .texel (ty)
  );

  // Carry region and destination alongside the axis stages
  logic        ax_reg_r  [4];
  logic [20:0] ax_dest_r [4];

  always_ff @(posedge clk) begin
    if (ax_en[0]) begin
      ax_reg_r[0]  <= dv_side.region;
      ax_dest_r[0] <= dv_side.dest;
    end
    for (int i = 1; i < 4; i++) begin
      if (ax_en[i]) begin
        ax_reg_r[i]  <= ax_reg_r[i-1];
        ax_dest_r[i] <= ax_dest_r[i-1];
      end
    end
  end

  // Output register: source index, zero fields outside the region
  logic        o_reg_r;
  logic [9:0]  o_tx_r, o_ty_r;
  logic [19:0] o_src_r;
  logic [20:0] o_dest_r;

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      o_reg_r <= ax_reg_r[3];
      if (ax_reg_r[3]) begin
        o_tx_r   <= tx;
        o_ty_r   <= ty;
        o_src_r  <= 20'({11'd0, ty} * {10'd0, tw_eff} + {11'd0, tx});
        o_dest_r <= ax_dest_r[3];
      end else begin
        o_tx_r   <= '0;
        o_ty_r   <= '0;
        o_src_r  <= '0;
        o_dest_r <= '0;
      end
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tuser  = o_reg_r;
  assign out_tdata  = {3'd0, o_dest_r, o_src_r, o_ty_r, o_tx_r};

  // Checks
  `FCC_ASSERT_SAME(a_zero_outside, out_tvalid && !out_tuser, out_tdata == 64'd0)
  `FCC_ASSERT_SAME(a_tx_in_tex, out_tvalid && out_tuser, {1'b0, out_tdata[9:0]} < tw_eff)
  `FCC_ASSERT_SAME(a_ty_in_tex, out_tvalid && out_tuser, {1'b0, out_tdata[19:10]} < th_eff)
  `FCC_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0])

endmodule

// File: rtl/core/fcc_div_cell.sv
// One restoring division step: one quotient bit per cell, registered.
// Depends on fcc_pkg for the divider and sideband types.
module fcc_div_cell (
  input  logic          clk,
  input  logic          en,
  input  fcc_pkg::div_t  div_i,
  input  fcc_pkg::side_t side_i,
  output fcc_pkg::div_t  div_o,
  output fcc_pkg::side_t side_o
);

  fcc_pkg::div_t  div_r, div_nxt;
  fcc_pkg::side_t side_r;
  logic [25:0]    trial;
  logic           ge;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    trial   = {div_i.rem, div_i.num_lo[23]};
    ge      = trial >= {1'b0, div_i.den};
    div_nxt = div_i;
    div_nxt.rem    = ge ? 25'(trial - {1'b0, div_i.den}) : trial[24:0];
    div_nxt.num_lo = {div_i.num_lo[22:0], 1'b0};
    div_nxt.quo    = {div_i.quo[22:0], ge};
  end

  // Hand the step to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= side_i;
    end
  end

  assign div_o  = div_r;
  assign side_o = side_r;

endmodule

// File: rtl/core/fcc_axis.sv
// Texel coordinate along one axis: offset, tile fraction, scale and clamp.
// Four register stages; depends on fcc_pkg for constants.
module fcc_axis (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic [23:0]        span,
  input  logic [23:0]        pos,
  input  logic signed [15:0] trig,
  input  logic [4:0]         fbits,
  input  logic [10:0]        tex,
  output logic [9:0]         texel
);

  logic signed [40:0] prod_r;
  logic [16:0]        pos_r;
  logic [4:0]         fb1_r, fb2_r, fb3_r;
  logic [16:0]        frac_r;
  logic [27:0]        scl_r;
  logic [9:0]         texel_r;
  logic [16:0]        world;
  logic [16:0]        mask;
  logic [27:0]        shifted;
  logic [9:0]         texel_nxt;

  // Stage 1: distance times direction
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= $signed({1'b0, span}) * trig;
      pos_r  <= pos[16:0];
      fb1_r  <= fbits;
    end
  end

  // Floor shift of the offset, add position, keep the tile fraction
  always_comb begin
    world = pos_r + 17'(prod_r >>> 14);
    case (fb1_r)
      fcc_pkg::FBITS_MIN: mask = 17'h07FFF;
      fcc_pkg::FBITS_MAX: mask = 17'h0FFFF;
      default:            mask = 17'h1FFFF;
    endcase
  end

  // Stage 2: tile fraction
  always_ff @(posedge clk) begin
    if (en[1]) begin
      frac_r <= world & mask;
      fb2_r  <= fb1_r;
    end
  end

  // Stage 3: scale to texture size
  always_ff @(posedge clk) begin
    if (en[2]) begin
      scl_r <= {11'd0, frac_r} * {17'd0, tex};
      fb3_r <= fb2_r;
    end
  end

  // Drop the fraction bits and clamp into the texture
  always_comb begin
    case (fb3_r)
      fcc_pkg::FBITS_MIN: shifted = scl_r >> 15;
      fcc_pkg::FBITS_MAX: shifted = scl_r >> 16;
      default:            shifted = scl_r >> 17;
    endcase
    if (shifted > {17'd0, tex - 11'd1}) texel_nxt = 10'(tex - 11'd1);
    else texel_nxt = shifted[9:0];
  end

  // Stage 4: texel
  always_ff @(posedge clk) begin
    if (en[3]) begin
      texel_r <= texel_nxt;
    end
  end

  assign texel = texel_r;

endmodule

// File: sim/testbench.sv
// Testbench for floor_ceiling_texel_caster: streams pixel requests with random gaps and
// output stalls, predicts each texel/destination address and checks every result in order.
// Depends on fcc_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        in_region;
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic [19:0] source_index;
    logic [20:0] dst_index;
  } texel_result_t;

  typedef struct {
    logic               surface;
    logic [9:0]         row;
    logic [10:0]        column;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [14:0]        view_cos;
  } pixel_req_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [119:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [63:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  floor_ceiling_texel_caster uut (.*);

  // Shadow copy of the registers
  logic [9:0]  sh_center;
  logic [10:0] sh_height;
  logic [11:0] sh_dwidth;
  logic [15:0] sh_eye;
  logic [11:0] sh_proj;
  logic [10:0] sh_tw, sh_th;
  logic [3:0]  sh_tile;

  texel_result_t expected_texels[$];
  int  fail_count;
  int  idle_cycles;
  bit  stall_on;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Texel along one axis: offset by distance, wrap to tile, scale, clamp
  function automatic logic [10:0] axis_coord(logic [23:0] pos, logic signed [15:0] trig,
                                             logic [23:0] span, int fbits,
                                             logic [10:0] tex);
    longint p, off, world, frac, t;
    p = longint'(span) * longint'(trig);
    if (p >= 0) off = p >>> 14;
    else off = -((-p + 16383) >>> 14);
    world = longint'(pos) + off;
    frac = world & ((longint'(1) << fbits) - 1);
    t = (frac * longint'(tex)) >>> fbits;
    if (t > tex - 1) t = tex - 1;
    return t[10:0];
  endfunction

  function automatic logic [10:0] tex_size(logic [10:0] v);
    if (v == 0) return 11'd1;
    if (v > 11'd1024) return 11'd1024;
    return v;
  endfunction

  function automatic texel_result_t cast_pixel(pixel_req_t q);
    texel_result_t r;
    longint lim, d, num, den, span;
    int fbits;
    bit region;
    logic [10:0] tw, th, tx, ty;
    r = '0;
    lim = (sh_height > 1024) ? 1024 : sh_height;
    if (!q.surface) begin
      region = q.row > sh_center && q.row < lim;
      d = longint'(q.row) - longint'(sh_center);
      fbits = (sh_tile < 7) ? 15 : ((sh_tile > 8) ? 16 : sh_tile + 8);
    end else begin
      region = q.row < sh_center;
      d = longint'(sh_center) - longint'(q.row);
      fbits = 17;
    end
    if (!region) return r;
    num = (longint'(sh_eye) * longint'(sh_proj)) << 18;
    den = longint'(q.view_cos) * d;
    span = 64'hFFFFFF;
    if (den != 0) begin
      span = num / den;
      if (span > 64'hFFFFFF) span = 64'hFFFFFF;
    end
    tw = tex_size(sh_tw);
    th = tex_size(sh_th);
    tx = axis_coord(q.player_x, q.dir_x, span[23:0], fbits, tw);
    ty = axis_coord(q.player_y, q.dir_y, span[23:0], fbits, th);
    r.in_region = 1'b1;
    r.texel_x = tx[9:0];
    r.texel_y = ty[9:0];
    r.source_index = 20'(longint'(ty) * tw + tx);
    r.dst_index = 21'(longint'(q.row) * sh_dwidth + q.column);
    return r;
  endfunction

  // Send one pixel request after a random gap; hold it until accepted
  task automatic send_pixel(pixel_req_t q);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= q.surface;
    in_tdata <= {4'b0, q.view_cos, q.dir_y, q.dir_x, q.player_y, q.player_x,
                 q.column, q.row};
    expected_texels.push_back(cast_pixel(q));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      fcc_pkg::REG_CENTER_ROW: sh_center = val[9:0];
      fcc_pkg::REG_SCREEN_H:   sh_height = val[10:0];
      fcc_pkg::REG_DEST_WIDTH: sh_dwidth = val[11:0];
      fcc_pkg::REG_EYE_HEIGHT: sh_eye = val[15:0];
      fcc_pkg::REG_PROJ_DIST:  sh_proj = val[11:0];
      fcc_pkg::REG_TEX_WIDTH:  sh_tw = val[10:0];
      fcc_pkg::REG_TEX_HEIGHT: sh_th = val[10:0];
      default:                 sh_tile = val[3:0];
    endcase
    @(posedge clk);
  endtask

  // Drop the input and wait for the pipeline to drain before touching registers
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_view(logic [9:0] c, logic [10:0] h, logic [11:0] w, logic [15:0] e,
                          logic [11:0] p, logic [10:0] tw, logic [10:0] th, logic [3:0] t);
    drain();
    write_reg(fcc_pkg::REG_CENTER_ROW, 32'(c));
    write_reg(fcc_pkg::REG_SCREEN_H, 32'(h));
    write_reg(fcc_pkg::REG_DEST_WIDTH, 32'(w));
    write_reg(fcc_pkg::REG_EYE_HEIGHT, 32'(e));
    write_reg(fcc_pkg::REG_PROJ_DIST, 32'(p));
    write_reg(fcc_pkg::REG_TEX_WIDTH, 32'(tw));
    write_reg(fcc_pkg::REG_TEX_HEIGHT, 32'(th));
    write_reg(fcc_pkg::REG_TILE_LOG2, 32'(t));
  endtask

  function automatic pixel_req_t random_pixel(bit aim_region);
    pixel_req_t q;
    int trig;
    q.surface = 1'($urandom_range(0, 1));
    q.row = 10'($urandom);
    if (aim_region) begin
      if (q.surface && sh_center > 0) q.row = 10'($urandom_range(0, sh_center - 1));
      else if (!q.surface && sh_center < 1022)
        q.row = 10'($urandom_range(sh_center + 1, (sh_height > 1023) ? 1023 :
                    ((sh_height > sh_center + 1) ? sh_height - 1 : sh_center + 1)));
    end
    q.column = 11'($urandom);
    q.player_x = 24'($urandom);
    q.player_y = 24'($urandom);
    trig = $urandom_range(0, 32768);
    q.dir_x = 16'(trig - 16384);
    trig = $urandom_range(0, 32768);
    q.dir_y = 16'(trig - 16384);
    q.view_cos = ($urandom_range(0, 15) == 0) ? 15'(16384 - $urandom_range(0, 3))
                                              : 15'($urandom_range(1, 16384));
    if ($urandom_range(0, 40) == 0) q.view_cos = 15'($urandom);
    return q;
  endfunction

  // Directed: field extremes, both surfaces, out of region, saturation, odd registers
  task automatic test_directed;
    pixel_req_t q;
    q = '{1'b0, 10'd241, 11'd0, 24'd0, 24'd0, 16'sd16384, 16'sd0, 15'd16384};
    send_pixel(q);
    q = '{1'b0, 10'd479, 11'd2047, 24'hFFFFFF, 24'hFFFFFF, -16'sd16384, -16'sd16384, 15'd1};
    send_pixel(q);
    q = '{1'b1, 10'd0, 11'd5, 24'h123456, 24'h654321, 16'sd11585, -16'sd11585, 15'd16384};
    send_pixel(q);
    q = '{1'b1, 10'd239, 11'd7, 24'h000100, 24'hFFFF00, -16'sd1, 16'sd16384, 15'd0};
    send_pixel(q);
    q = '{1'b0, 10'd240, 11'd3, 24'd5, 24'd5, 16'sd100, 16'sd100, 15'd100};
    send_pixel(q);
    q = '{1'b1, 10'd240, 11'd3, 24'd5, 24'd5, 16'sd100, 16'sd100, 15'd100};
    send_pixel(q);
    q = '{1'b0, 10'd480, 11'd3, 24'd5, 24'd5, 16'sd100, 16'sd100, 15'd100};
    send_pixel(q);
    q = '{1'b0, 10'd1023, 11'd1, 24'd5, 24'd5, 16'sd100, 16'sd100, 15'h7FFF};
    send_pixel(q);
    // Zero texture width, oversize screen and texture height, low tile log2
    set_view(10'd0, 11'd2047, 12'd4095, 16'hFFFF, 12'd4095, 11'd0, 11'd2047, 4'd0);
    q = '{1'b0, 10'd1, 11'd2047, 24'h00FF00, 24'hABCDEF, 16'sd16384, 16'sd16384, 15'd1};
    send_pixel(q);
    q = '{1'b0, 10'd1023, 11'd2047, 24'h800000, 24'h7FFFFF, -16'sd16384, 16'sd3, 15'd16384};
    send_pixel(q);
    q = '{1'b1, 10'd0, 11'd0, 24'd1, 24'd1, 16'sd1, 16'sd1, 15'd1};
    send_pixel(q);
    set_view(10'd1023, 11'd1, 12'd1, 16'd0, 12'd1, 11'd1024, 11'd1, 4'd15);
    q = '{1'b1, 10'd0, 11'd9, 24'hFFFFFF, 24'd0, -16'sd16384, 16'sd16384, 15'd16384};
    send_pixel(q);
    q = '{1'b1, 10'd1022, 11'd9, 24'hABCDEF, 24'd77, 16'sd5, -16'sd5, 15'd1};
    send_pixel(q);
    q = '{1'b0, 10'd0, 11'd9, 24'd0, 24'd0, 16'sd0, 16'sd0, 15'd1};
    send_pixel(q);
  endtask

  // Random phases over several register settings
  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_view(10'd240, 11'd480, 12'd640, 16'd512, 12'd554, 11'd64, 11'd64, 4'd8);
      else if (ph == 1)
        set_view(10'd512, 11'd1024, 12'd2048, 16'd16, 12'd100, 11'd128, 11'd256, 4'd7);
      else
        set_view(10'($urandom), 11'($urandom_range(1, 1100)), 12'($urandom_range(1, 2048)),
                 16'($urandom), 12'($urandom_range(1, 4095)), 11'($urandom_range(0, 1100)),
                 11'($urandom_range(0, 1100)), 4'($urandom));
      stall_on = (ph % 3) != 2;
      for (int i = 0; i < 250; i++) send_pixel(random_pixel($urandom_range(0, 4) != 0));
    end
  endtask

  // Output stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (!stall_on) out_tready <= 1'b1;
    else out_tready <= $urandom_range(0, 7) < 5;
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    texel_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[9:0], out_tdata[19:10], out_tdata[39:20], out_tdata[60:40]};
      if (expected_texels.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_texels.pop_front();
        if (got.in_region !== want.in_region) begin
          $error("in_region exp %0d got %0d", want.in_region, got.in_region); fail_count++;
        end
        if (got.texel_x !== want.texel_x) begin
          $error("texel_x exp %0d got %0d", want.texel_x, got.texel_x); fail_count++;
        end
        if (got.texel_y !== want.texel_y) begin
          $error("texel_y exp %0d got %0d", want.texel_y, got.texel_y); fail_count++;
        end
        if (got.source_index !== want.source_index) begin
          $error("source_index exp %0d got %0d", want.source_index, got.source_index);
          fail_count++;
        end
        if (got.dst_index !== want.dst_index) begin
          $error("dst_index exp %0d got %0d", want.dst_index, got.dst_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("floor_ceiling_texel_caster test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    stall_on = 1;
    sh_center = 240; sh_height = 480; sh_dwidth = 640; sh_eye = 512; sh_proj = 554;
    sh_tw = 64; sh_th = 64; sh_tile = 8;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (fail_count == 0) $display("floor_ceiling_texel_caster test passed");
    else $display("floor_ceiling_texel_caster test failed");
    $finish;
  end
endmodule
